### hdl/wildcard_byte_pattern_scan_assert.svh
// Assertion macros shared by the scan RTL.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define WBPS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("scan assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define WBPS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("scan assertion failed");

`endif

### hdl/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int OFFSET_WIDTH      = 32;
    localparam int SIG_BYTES         = 16;
    localparam int LEN_W             = 5;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;
    localparam int ADDR_W            = 64;
    localparam int LEN_IDX_W         = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_ADDRESS       = 3'd0,
        REG_PATTERN_BYTES_LOW  = 3'd1,
        REG_PATTERN_BYTES_HIGH = 3'd2,
        REG_CARE_MASK          = 3'd3,
        REG_PATTERN_LENGTH     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]      base_address;
        logic [8*SIG_BYTES-1:0] pattern_bytes;
        logic [SIG_BYTES-1:0]   care_mask;
        logic [LEN_W-1:0]       pattern_length;
    } cfg_t;

    typedef struct packed {
        logic advance;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic                    found;
        logic [OFFSET_WIDTH-1:0] start_offset;
    } result_t;

endpackage

`default_nettype wire

### hdl/wbps_cfg.sv
`default_nettype none

module wbps_cfg
    import wbps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    logic [ADDR_W-1:0]    base_reg;
    logic [63:0]          low_reg;
    logic [63:0]          high_reg;
    logic [SIG_BYTES-1:0] care_reg;
    logic [LEN_W-1:0]     len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            low_reg  <= '0;
            high_reg <= '0;
            care_reg <= '1;
            len_reg  <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BASE_ADDRESS:       base_reg <= cfg_data[ADDR_W-1:0];
                REG_PATTERN_BYTES_LOW:  low_reg  <= cfg_data[63:0];
                REG_PATTERN_BYTES_HIGH: high_reg <= cfg_data[63:0];
                REG_CARE_MASK:          care_reg <= cfg_data[SIG_BYTES-1:0];
                REG_PATTERN_LENGTH:     len_reg  <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.base_address   = base_reg;
    assign cfg.pattern_bytes  = {high_reg, low_reg};
    assign cfg.care_mask      = care_reg;
    assign cfg.pattern_length = len_reg;

endmodule

`default_nettype wire

### hdl/wbps_cell.sv
`default_nettype none

module wbps_cell
    import wbps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] pattern_byte,
    input  wire logic       care,
    input  wire logic       enable,
    input  wire logic       prev_match,
    output logic            match_next,
    output logic            match
);

    logic match_reg;

    // positions 0..j match, ending at the current byte
    assign match_next = prev_match & enable & (~care | (data_byte == pattern_byte));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            match_reg <= ctrl.clear ? 1'b0 : match_next;
        end
    end

    assign match = match_reg;

endmodule

`default_nettype wire

### hdl/wbps_out_stage.sv
`default_nettype none

module wbps_out_stage
    import wbps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_valid,
    input  wire result_t           res,
    output logic                   res_ready,
    input  wire logic [ADDR_W-1:0] base_address,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_item
);

    logic      valid_reg;
    out_item_t item_reg;
    out_item_t item_next;

    assign res_ready = ~valid_reg | out_ready;

    always_comb
    begin
        item_next.found         = res.found;
        item_next.match_address = res.found
            ? base_address + ADDR_W'(res.start_offset)
            : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

### hdl/wildcard_byte_pattern_scan.sv
// Masked byte signature search over a streamed memory image.
// in channel (in_valid/in_ready/in_item): one image byte per request, with
// last_byte marking the end of the image. out channel (out_valid/out_ready/
// out_item): at most one result per image, found=1 with base plus start
// offset of the earliest match, or found=0 with address zero at the end of
// an image without a match. Bytes after a reported match give no result.
// Configuration: cfg_write/cfg_index/cfg_data, to be written by the user only
// while idle; the block does not enforce this. Throughput: one byte per cycle
// while in_ready is high; each byte goes through the row of match cells in
// the cycle it is accepted. The edge that accepts a byte causing a result
// loads the middle stage (offset subtract); the 64-bit base add then goes
// into the output register, which raises out_valid. Stall: a pending result
// waits in the middle stage; in_ready drops only when both the middle stage
// and the output register hold results that cannot move.
// Reset: match vector, offset and reported flag clear, no result pending;
// base and pattern bytes zero, care mask all ones, length one.
`default_nettype none

`include "wildcard_byte_pattern_scan_assert.svh"

module wildcard_byte_pattern_scan
    import wbps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_item,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t                         cfg;
    cell_ctrl_t                   ctrl;
    logic [LEN_IDX_W-1:0]         len_m1;
    logic [MAX_PATTERN_BYTES-1:0] match_vec;
    logic [MAX_PATTERN_BYTES-1:0] match_next;
    logic                         accept;
    logic                         hit;
    logic                         emit;
    logic                         s1_ready;
    logic                         s1_valid_reg;
    result_t                      s1_reg;
    logic                         reported_reg;
    logic [OFFSET_WIDTH-1:0]      offset_reg;
    logic [OFFSET_WIDTH-1:0]      start_offset;

    wbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // effective length minus one, clamped to 1..MAX_PATTERN_BYTES
    always_comb
    begin
        if (cfg.pattern_length == '0)
        begin
            len_m1 = '0;
        end
        else if (int'(cfg.pattern_length) > MAX_PATTERN_BYTES)
        begin
            len_m1 = LEN_IDX_W'(MAX_PATTERN_BYTES - 1);
        end
        else
        begin
            len_m1 = LEN_IDX_W'(cfg.pattern_length - LEN_W'(1));
        end
    end

    assign accept       = in_valid & in_ready;
    assign ctrl.advance = accept;
    assign ctrl.clear   = in_item.last_byte;

    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++)
    begin : g_cell
        logic [7:0] pattern_byte;
        logic       care;
        logic       prev_match;

        if (j < SIG_BYTES)
        begin : g_sig
            assign pattern_byte = cfg.pattern_bytes[8*j +: 8];
            assign care         = cfg.care_mask[j];
        end
        else
        begin : g_wild
            assign pattern_byte = 8'h00;
            assign care         = 1'b0;
        end

        if (j == 0)
        begin : g_head
            assign prev_match = 1'b1;
        end
        else
        begin : g_link
            assign prev_match = match_vec[j-1];
        end

        wbps_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .data_byte    (in_item.data_byte),
            .pattern_byte (pattern_byte),
            .care         (care),
            .enable       (len_m1 >= LEN_IDX_W'(j)),
            .prev_match   (prev_match),
            .match_next   (match_next[j]),
            .match        (match_vec[j])
        );
    end

    assign hit          = match_next[len_m1] & ~reported_reg;
    assign emit         = hit | (in_item.last_byte & ~reported_reg);
    assign start_offset = offset_reg - OFFSET_WIDTH'(len_m1);
    assign in_ready     = ~s1_valid_reg | s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= 1'b0;
            offset_reg   <= '0;
        end
        else if (accept)
        begin
            reported_reg <= in_item.last_byte ? 1'b0 : (reported_reg | hit);
            offset_reg   <= in_item.last_byte ? '0 : offset_reg + OFFSET_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            s1_reg.found        <= hit;
            s1_reg.start_offset <= start_offset;
        end
    end

    wbps_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (s1_valid_reg),
        .res          (s1_reg),
        .res_ready    (s1_ready),
        .base_address (cfg.base_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_item     (out_item)
    );

    `WBPS_ASSERT_NOW(a_notfound_zero, out_valid && !out_item.found, out_item.match_address == '0)
    `WBPS_ASSERT_NOW(a_stall_only_full, !in_ready, s1_valid_reg && !s1_ready)
    `WBPS_ASSERT_NEXT(a_image_end_clears, accept && in_item.last_byte,
                      !reported_reg && offset_reg == '0 && match_vec == '0)
    `WBPS_ASSERT_NEXT(a_hit_queued, accept && hit, s1_valid_reg && s1_reg.found)

endmodule

`default_nettype wire
